// ===== hdl/tccu_pkg.sv =====
// ----------------------------------------------------------------------------
// tccu_pkg
// Shared types, codes and microcode ROM of the text console cursor engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tccu_pkg;

  localparam int POS_W   = 12;
  localparam int GLYPH_W = 8;
  localparam int CA_W    = 6;
  localparam int DIM_W   = 12;
  localparam int CMD_W   = 2;
  localparam int CFG_AW  = 2;
  localparam int ADDR_W  = 5;

  localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

  localparam logic [CFG_AW-1:0] REG_CHAR_ADVANCE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 2'd2;

  localparam logic [GLYPH_W-1:0] CH_BS    = 8'd8;
  localparam logic [GLYPH_W-1:0] CH_TAB   = 8'd9;
  localparam logic [GLYPH_W-1:0] CH_NL    = 8'd10;
  localparam logic [GLYPH_W-1:0] CH_CR    = 8'd13;
  localparam logic [GLYPH_W-1:0] CH_SPACE = 8'd32;

  localparam logic [CA_W:0] LINE_PAD = 7'd4;

  localparam logic [CA_W-1:0] CA_RESET = 6'd8;
  localparam logic [DIM_W-1:0] SW_RESET = 12'd640;
  localparam logic [DIM_W-1:0] SH_RESET = 12'd480;

  typedef enum logic [4:0] {
    OP_WAIT,
    OP_DISP,
    OP_DRAW,
    OP_ADVX,
    OP_WRAP,
    OP_SCROLL,
    OP_STORE,
    OP_TABLOOP,
    OP_END,
    OP_DIVCOL,
    OP_DIVSW,
    OP_DIVSTEP,
    OP_TABN,
    OP_NL,
    OP_CR,
    OP_BSX,
    OP_BSY,
    OP_BSWRAP,
    OP_ERASE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] tgt;
  } ctrl_t;

  localparam logic [ADDR_W-1:0] A_IDLE    = 5'd0;
  localparam logic [ADDR_W-1:0] A_DISP    = 5'd1;
  localparam logic [ADDR_W-1:0] A_PRINT   = 5'd2;
  localparam logic [ADDR_W-1:0] A_ADVX    = 5'd3;
  localparam logic [ADDR_W-1:0] A_WRAP    = 5'd4;
  localparam logic [ADDR_W-1:0] A_PSCRL   = 5'd5;
  localparam logic [ADDR_W-1:0] A_PSTORE  = 5'd6;
  localparam logic [ADDR_W-1:0] A_TLOOP   = 5'd7;
  localparam logic [ADDR_W-1:0] A_TAIL    = 5'd8;
  localparam logic [ADDR_W-1:0] A_TSTORE  = 5'd9;
  localparam logic [ADDR_W-1:0] A_END     = 5'd10;
  localparam logic [ADDR_W-1:0] A_TAB     = 5'd11;
  localparam logic [ADDR_W-1:0] A_TDIV    = 5'd12;
  localparam logic [ADDR_W-1:0] A_TABN    = 5'd13;
  localparam logic [ADDR_W-1:0] A_NL      = 5'd14;
  localparam logic [ADDR_W-1:0] A_CR      = 5'd15;
  localparam logic [ADDR_W-1:0] A_BS      = 5'd16;
  localparam logic [ADDR_W-1:0] A_BSY     = 5'd17;
  localparam logic [ADDR_W-1:0] A_BSDIV   = 5'd18;
  localparam logic [ADDR_W-1:0] A_BSDSTEP = 5'd19;
  localparam logic [ADDR_W-1:0] A_BSWRAP  = 5'd20;
  localparam logic [ADDR_W-1:0] A_ERASE   = 5'd21;

  // tgt: branch target when the step's condition is taken
  function automatic ctrl_t ucode(input logic [ADDR_W-1:0] a);
    ctrl_t w;
    unique case (a)
      A_IDLE:    w = '{op: OP_WAIT,    tgt: A_DISP};
      A_DISP:    w = '{op: OP_DISP,    tgt: A_PRINT};
      A_PRINT:   w = '{op: OP_DRAW,    tgt: A_ADVX};
      A_ADVX:    w = '{op: OP_ADVX,    tgt: A_WRAP};
      A_WRAP:    w = '{op: OP_WRAP,    tgt: A_PSCRL};
      A_PSCRL:   w = '{op: OP_SCROLL,  tgt: A_PSTORE};
      A_PSTORE:  w = '{op: OP_STORE,   tgt: A_TLOOP};
      A_TLOOP:   w = '{op: OP_TABLOOP, tgt: A_PRINT};
      A_TAIL:    w = '{op: OP_SCROLL,  tgt: A_TSTORE};
      A_TSTORE:  w = '{op: OP_STORE,   tgt: A_END};
      A_END:     w = '{op: OP_END,     tgt: A_IDLE};
      A_TAB:     w = '{op: OP_DIVCOL,  tgt: A_TDIV};
      A_TDIV:    w = '{op: OP_DIVSTEP, tgt: A_TDIV};
      A_TABN:    w = '{op: OP_TABN,    tgt: A_PRINT};
      A_NL:      w = '{op: OP_NL,      tgt: A_TAIL};
      A_CR:      w = '{op: OP_CR,      tgt: A_TAIL};
      A_BS:      w = '{op: OP_BSX,     tgt: A_ERASE};
      A_BSY:     w = '{op: OP_BSY,     tgt: A_TAIL};
      A_BSDIV:   w = '{op: OP_DIVSW,   tgt: A_BSDSTEP};
      A_BSDSTEP: w = '{op: OP_DIVSTEP, tgt: A_BSDSTEP};
      A_BSWRAP:  w = '{op: OP_BSWRAP,  tgt: A_ERASE};
      A_ERASE:   w = '{op: OP_ERASE,   tgt: A_TAIL};
      default:   w = '{op: OP_END,     tgt: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/text_console_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Microcoded cursor engine: turns character words into draw, erase and
// scroll command words for a framebuffer executor.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_char_code        | character words in
//  out     | out_valid, out_stall, out_command,      | command words out
//          | out_pos_x, out_pos_y, out_glyph, out_last|
//  cfg     | cfg_we, cfg_addr, cfg_wdata             | register writes
//
//  One micro-op per cycle from the control ROM while no step waits on the
//  output. Tab and backspace wrap use the one-bit-per-cycle restoring divider
//  of max(COORD_BITS, 12) bits; a tab prints its spaces through the print steps.
//  Reset: synchronous, clears cursor to 0 and registers to 8 / 640 / 480.
//  in_stall is high except in the idle step. The last command is held back
//  one word to mark it; an emit step waits while that word is held and the
//  output register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine_unit
  import tccu_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int TAB_STOP   = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [GLYPH_W-1:0] in_char_code,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CMD_W-1:0]        out_command,
  output logic [POS_W-1:0]        out_pos_x,
  output logic [POS_W-1:0]        out_pos_y,
  output logic [GLYPH_W-1:0]      out_glyph,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic [CFG_AW-1:0]  cfg_addr,
  input  wire logic [DIM_W-1:0]   cfg_wdata
);

  localparam int CW = COORD_BITS;
  localparam int DW = (CW > DIM_W) ? CW : DIM_W;
  localparam int W  = DW + 2;
  localparam int KW = $clog2(DW + 1);
  localparam int NW = $clog2(TAB_STOP + 1);
  localparam int QW = NW + 1;

  // control state
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [CA_W-1:0]   ca_r;
  logic [DIM_W-1:0]  sw_r;
  logic [DIM_W-1:0]  sh_r;

  // datapath
  logic [W-1:0]       x_r, x_nxt;
  logic [W-1:0]       y_r, y_nxt;
  logic [GLYPH_W-1:0] ch_r, ch_nxt;
  logic [GLYPH_W-1:0] g_r, g_nxt;
  logic               tab_r, tab_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic [DW-1:0]      dvd_r, dvd_nxt;
  logic [CA_W-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]      qm_r, qm_nxt;
  logic [KW-1:0]      k_r, k_nxt;

  logic [CMD_W-1:0]   pend_cmd_r, pend_cmd_nxt;
  logic [POS_W-1:0]   pend_x_r, pend_x_nxt;
  logic [POS_W-1:0]   pend_y_r, pend_y_nxt;
  logic [GLYPH_W-1:0] pend_g_r, pend_g_nxt;

  logic [CMD_W-1:0]   out_cmd_r;
  logic [POS_W-1:0]   out_x_r;
  logic [POS_W-1:0]   out_y_r;
  logic [GLYPH_W-1:0] out_g_r;
  logic               out_last_r;

  ctrl_t        cw;
  logic [CA_W-1:0] s;
  logic [W-1:0] s_w, lh_w, sw_w, sh_w;
  logic         room, emit_ok, accept;
  logic         emit;
  logic [CMD_W-1:0]   emit_cmd;
  logic [POS_W-1:0]   emit_x, emit_y;
  logic [GLYPH_W-1:0] emit_g;
  logic         push, push_last;
  logic [CA_W:0] rem2;
  logic         qbit;
  logic [QW-1:0] qm2;
  logic [ADDR_W-1:0] pc_inc;

  assign cw     = ucode(pc_r);
  assign s      = (ca_r == '0) ? CA_W'(1) : ca_r;
  assign s_w    = W'(s);
  assign lh_w   = W'({1'b0, s} + LINE_PAD);
  assign sw_w   = W'(sw_r);
  assign sh_w   = W'(sh_r);
  assign room   = !out_valid_r || !out_stall;
  assign emit_ok = !pend_v_r || room;
  assign accept = in_valid && !in_stall;
  assign pc_inc = pc_r + ADDR_W'(1);

  assign rem2 = {rem_r, dvd_r[DW-1]};
  assign qbit = (rem2 >= {1'b0, s});
  assign qm2  = {qm_r[QW-2:0], qbit};

  assign in_stall    = (pc_r != A_IDLE);
  assign out_valid   = out_valid_r;
  assign out_command = out_cmd_r;
  assign out_pos_x   = out_x_r;
  assign out_pos_y   = out_y_r;
  assign out_glyph   = out_g_r;
  assign out_last    = out_last_r;

  always_comb begin
    pc_nxt   = pc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    ch_nxt   = ch_r;
    g_nxt    = g_r;
    tab_nxt  = tab_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    qm_nxt   = qm_r;
    k_nxt    = k_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    emit     = 1'b0;
    emit_cmd = CMD_DRAW;
    emit_x   = '0;
    emit_y   = '0;
    emit_g   = '0;
    push_last = 1'b0;
    push     = 1'b0;

    case (cw.op)
      OP_WAIT: begin
        if (accept) begin
          pc_nxt  = cw.tgt;
          ch_nxt  = in_char_code;
          g_nxt   = in_char_code;
          tab_nxt = 1'b0;
          x_nxt   = W'(col_r);
          y_nxt   = W'(row_r);
        end
      end
      OP_DISP: begin
        case (ch_r)
          CH_TAB:  pc_nxt = A_TAB;
          CH_NL:   pc_nxt = A_NL;
          CH_CR:   pc_nxt = A_CR;
          CH_BS:   pc_nxt = A_BS;
          default: pc_nxt = cw.tgt;
        endcase
      end
      OP_DRAW: begin
        if (emit_ok) begin
          emit     = 1'b1;
          emit_cmd = CMD_DRAW;
          emit_x   = x_r[POS_W-1:0];
          emit_y   = y_r[POS_W-1:0];
          emit_g   = g_r;
          pc_nxt   = pc_inc;
        end
      end
      OP_ADVX: begin
        x_nxt  = x_r + s_w;
        pc_nxt = pc_inc;
      end
      OP_WRAP: begin
        if (x_r + s_w >= sw_w) begin
          x_nxt = '0;
          y_nxt = y_r + lh_w;
        end
        pc_nxt = pc_inc;
      end
      OP_SCROLL: begin
        if (y_r + lh_w >= sh_w) begin
          if (emit_ok) begin
            emit     = 1'b1;
            emit_cmd = CMD_SCROLL;
            y_nxt    = (y_r >= lh_w) ? y_r - lh_w : '0;
            pc_nxt   = pc_inc;
          end
        end else begin
          pc_nxt = pc_inc;
        end
      end
      OP_STORE: begin
        col_nxt = x_r[CW-1:0];
        row_nxt = y_r[CW-1:0];
        x_nxt   = W'(x_r[CW-1:0]);
        y_nxt   = W'(y_r[CW-1:0]);
        pc_nxt  = pc_inc;
      end
      OP_TABLOOP: begin
        if (!tab_r) begin
          pc_nxt = A_END;
        end else if (cnt_r != NW'(1)) begin
          cnt_nxt = cnt_r - NW'(1);
          pc_nxt  = cw.tgt;
        end else begin
          pc_nxt = pc_inc;
        end
      end
      OP_END: begin
        if (pend_v_r) begin
          if (room) begin
            push      = 1'b1;
            push_last = 1'b1;
            pc_nxt    = cw.tgt;
          end
        end else begin
          pc_nxt = cw.tgt;
        end
      end
      OP_DIVCOL, OP_DIVSW: begin
        dvd_nxt = (cw.op == OP_DIVCOL) ? DW'(col_r) : DW'(sw_r);
        rem_nxt = '0;
        qm_nxt  = '0;
        k_nxt   = KW'(DW);
        pc_nxt  = cw.tgt;
      end
      OP_DIVSTEP: begin
        rem_nxt = qbit ? CA_W'(rem2 - {1'b0, s}) : CA_W'(rem2);
        qm_nxt  = (qm2 >= QW'(TAB_STOP)) ? qm2 - QW'(TAB_STOP) : qm2;
        dvd_nxt = {dvd_r[DW-2:0], 1'b0};
        k_nxt   = k_r - KW'(1);
        pc_nxt  = (k_r == KW'(1)) ? pc_inc : cw.tgt;
      end
      OP_TABN: begin
        cnt_nxt = NW'(TAB_STOP) - qm_r[NW-1:0];
        tab_nxt = 1'b1;
        g_nxt   = CH_SPACE;
        pc_nxt  = cw.tgt;
      end
      OP_NL: begin
        x_nxt  = '0;
        y_nxt  = y_r + lh_w;
        pc_nxt = cw.tgt;
      end
      OP_CR: begin
        x_nxt  = '0;
        pc_nxt = cw.tgt;
      end
      OP_BSX: begin
        if (x_r >= s_w) begin
          x_nxt  = x_r - s_w;
          pc_nxt = cw.tgt;
        end else begin
          pc_nxt = pc_inc;
        end
      end
      OP_BSY: begin
        if (y_r >= lh_w) begin
          y_nxt  = y_r - lh_w;
          pc_nxt = pc_inc;
        end else begin
          pc_nxt = cw.tgt;
        end
      end
      OP_BSWRAP: begin
        // last full cell of the line: width minus remainder minus one cell
        x_nxt  = (sw_r < DIM_W'(s)) ? '0 : sw_w - W'(rem_r) - s_w;
        pc_nxt = cw.tgt;
      end
      OP_ERASE: begin
        if (emit_ok) begin
          emit     = 1'b1;
          emit_cmd = CMD_ERASE;
          emit_x   = x_r[POS_W-1:0];
          emit_y   = y_r[POS_W-1:0];
          pc_nxt   = cw.tgt;
        end
      end
      default: pc_nxt = A_IDLE;
    endcase

    if (emit && pend_v_r) begin
      push = 1'b1;
    end
  end

  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_cmd_nxt = pend_cmd_r;
    pend_x_nxt   = pend_x_r;
    pend_y_nxt   = pend_y_r;
    pend_g_nxt   = pend_g_r;
    if (emit) begin
      pend_v_nxt   = 1'b1;
      pend_cmd_nxt = emit_cmd;
      pend_x_nxt   = emit_x;
      pend_y_nxt   = emit_y;
      pend_g_nxt   = emit_g;
    end else if (push) begin
      pend_v_nxt = 1'b0;
    end
    out_valid_nxt = room ? push : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= A_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      ca_r        <= CA_RESET;
      sw_r        <= SW_RESET;
      sh_r        <= SH_RESET;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_CHAR_ADVANCE:  ca_r <= cfg_wdata[CA_W-1:0];
          REG_SCREEN_WIDTH:  sw_r <= cfg_wdata;
          REG_SCREEN_HEIGHT: sh_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    ch_r       <= ch_nxt;
    g_r        <= g_nxt;
    tab_r      <= tab_nxt;
    cnt_r      <= cnt_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    qm_r       <= qm_nxt;
    k_r        <= k_nxt;
    pend_cmd_r <= pend_cmd_nxt;
    pend_x_r   <= pend_x_nxt;
    pend_y_r   <= pend_y_nxt;
    pend_g_r   <= pend_g_nxt;
    if (push) begin
      out_cmd_r  <= pend_cmd_r;
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_g_r    <= pend_g_r;
      out_last_r <= push_last;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tccu_cmd_checker.sv =====
// ----------------------------------------------------------------------------
// tccu_cmd_checker
// Watches the character, command and register ports of the cursor engine,
// keeps its own copy of cursor and registers, predicts the command words of
// each accepted character and compares them in order with the words that
// leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccu_cmd_checker
  import tccu_pkg::*;
#(
  parameter int TAB_CELLS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [GLYPH_W-1:0] in_char_code,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [CMD_W-1:0]   out_command,
  input  wire logic [POS_W-1:0]   out_pos_x,
  input  wire logic [POS_W-1:0]   out_pos_y,
  input  wire logic [GLYPH_W-1:0] out_glyph,
  input  wire logic               out_last,
  input  wire logic               cfg_we,
  input  wire logic [CFG_AW-1:0]  cfg_addr,
  input  wire logic [DIM_W-1:0]   cfg_wdata,
  output int                      fail_count,
  output int                      words_owed
);

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [GLYPH_W-1:0] glyph;
    logic               last;
  } cmd_word_t;

  logic [CA_W-1:0]  adv_q;
  logic [DIM_W-1:0] wid_q;
  logic [DIM_W-1:0] hgt_q;
  logic [POS_W-1:0] col_q;
  logic [POS_W-1:0] row_q;

  cmd_word_t char_words[$];
  cmd_word_t owed_words[$];

  function automatic int unsigned cell_px();
    return (adv_q == 0) ? 1 : int'(adv_q);
  endfunction

  function automatic void note_cmd(logic [CMD_W-1:0] cmd, int unsigned x, int unsigned y,
                                   int unsigned g);
    cmd_word_t w;
    w.command = cmd;
    w.pos_x   = x[POS_W-1:0];
    w.pos_y   = y[POS_W-1:0];
    w.glyph   = g[GLYPH_W-1:0];
    w.last    = 1'b0;
    char_words.push_back(w);
  endfunction

  function automatic int unsigned scroll_fix(int unsigned y);
    int unsigned lh;
    lh = cell_px() + LINE_PAD;
    if (y + lh >= hgt_q) begin
      note_cmd(CMD_SCROLL, 0, 0, 0);
      y = (y >= lh) ? y - lh : 0;
    end
    return y;
  endfunction

  function automatic void print_glyph(logic [GLYPH_W-1:0] c);
    int unsigned s;
    int unsigned x;
    int unsigned y;
    s = cell_px();
    x = col_q;
    y = row_q;
    note_cmd(CMD_DRAW, x, y, c);
    x += s;
    if (x + s >= wid_q) begin
      x = 0;
      y += s + LINE_PAD;
    end
    y = scroll_fix(y);
    col_q = x[POS_W-1:0];
    row_q = y[POS_W-1:0];
  endfunction

  function automatic void predict_char(logic [GLYPH_W-1:0] c);
    int unsigned s;
    int unsigned lh;
    int unsigned x;
    int unsigned y;
    int unsigned n;
    int unsigned per_line;
    char_words.delete();
    s  = cell_px();
    lh = s + LINE_PAD;
    if (c == CH_TAB) begin
      n = TAB_CELLS - (col_q / s) % TAB_CELLS;
      for (int unsigned i = 0; i < n; i++) print_glyph(CH_SPACE);
      y = scroll_fix(row_q);
      row_q = y[POS_W-1:0];
    end else if (c == CH_NL || c == CH_CR || c == CH_BS) begin
      x = col_q;
      y = row_q;
      if (c == CH_NL) begin
        x = 0;
        y += lh;
      end else if (c == CH_CR) begin
        x = 0;
      end else if (x >= s) begin
        x -= s;
        note_cmd(CMD_ERASE, x, y, 0);
      end else if (y >= lh) begin
        // wrap back to the last full cell of the line above
        per_line = wid_q / s;
        y -= lh;
        x = (per_line == 0) ? 0 : (per_line - 1) * s;
        note_cmd(CMD_ERASE, x, y, 0);
      end
      y = scroll_fix(y);
      col_q = x[POS_W-1:0];
      row_q = y[POS_W-1:0];
    end else begin
      print_glyph(c);
    end
    if (char_words.size() > 0) char_words[char_words.size() - 1].last = 1'b1;
    foreach (char_words[i]) owed_words.push_back(char_words[i]);
  endfunction

  function automatic bit field_bad(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    cmd_word_t w;
    bit bad;
    if (!rst_n) begin
      adv_q = CA_RESET;
      wid_q = SW_RESET;
      hgt_q = SH_RESET;
      col_q = '0;
      row_q = '0;
      owed_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CHAR_ADVANCE:  adv_q = cfg_wdata[CA_W-1:0];
          REG_SCREEN_WIDTH:  wid_q = cfg_wdata;
          REG_SCREEN_HEIGHT: hgt_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_char(in_char_code);
      if (out_valid && !out_stall) begin
        if (owed_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word: expected none, actual cmd %0d x %0d y %0d",
                   $time, out_command, out_pos_x, out_pos_y);
        end else begin
          w = owed_words.pop_front();
          bad = field_bad("command", w.command, out_command)
              | field_bad("pos_x", w.pos_x, out_pos_x)
              | field_bad("pos_y", w.pos_y, out_pos_y)
              | field_bad("glyph", w.glyph, out_glyph)
              | field_bad("last", w.last, out_last);
          if (bad) fail_count++;
        end
      end
    end
    words_owed = owed_words.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb_text_console_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine_unit
// Drives character words into the cursor engine under several register
// settings, stalls the command side in random bursts, and reports the verdict
// from the failure count and the owed word count of the command checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_text_console_cursor_engine_unit;
  import tccu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 64;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [GLYPH_W-1:0] in_char_code;
  logic               out_valid;
  logic               out_stall;
  logic [CMD_W-1:0]   out_command;
  logic [POS_W-1:0]   out_pos_x;
  logic [POS_W-1:0]   out_pos_y;
  logic [GLYPH_W-1:0] out_glyph;
  logic               out_last;
  logic               cfg_we;
  logic [CFG_AW-1:0]  cfg_addr;
  logic [DIM_W-1:0]   cfg_wdata;
  int                 fail_count;
  int                 words_owed;
  int                 cycles = 0;
  bit                 quiet = 1'b0;

  always #10 clk = ~clk;

  text_console_cursor_engine_unit uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_char_code,
    .out_valid, .out_stall, .out_command, .out_pos_x, .out_pos_y, .out_glyph, .out_last,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  tccu_cmd_checker cmd_chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_char_code,
    .out_valid, .out_stall, .out_command, .out_pos_x, .out_pos_y, .out_glyph, .out_last,
    .cfg_we, .cfg_addr, .cfg_wdata,
    .fail_count, .words_owed
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // command side backpressure: bursts of stall between free stretches
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  task automatic send_char(input logic [GLYPH_W-1:0] c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_char_code = c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_screen(input logic [DIM_W-1:0] adv, input logic [DIM_W-1:0] wid,
                            input logic [DIM_W-1:0] hgt);
    settle();
    set_reg(REG_CHAR_ADVANCE, adv);
    set_reg(REG_SCREEN_WIDTH, wid);
    set_reg(REG_SCREEN_HEIGHT, hgt);
  endtask

  function automatic logic [GLYPH_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return GLYPH_W'($urandom_range(32, 126));
    if (r < 65) return CH_NL;
    if (r < 73) return CH_TAB;
    if (r < 81) return CH_BS;
    if (r < 86) return CH_CR;
    return GLYPH_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return DIM_W'($urandom_range(1, 40));
    if (r < 8) return DIM_W'($urandom_range(40, 700));
    if (r < 9) return DIM_W'($urandom_range(700, 4095));
    return (r[0]) ? 12'd4095 : 12'd1;
  endfunction

  function automatic logic [DIM_W-1:0] pick_adv();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 7) return DIM_W'($urandom_range(1, 12));
    if (r < 9) return DIM_W'($urandom_range(13, 32));
    return DIM_W'($urandom_range(33, 63));
  endfunction

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = '0;
    cfg_we       = 1'b0;
    cfg_addr     = REG_CHAR_ADVANCE;
    cfg_wdata    = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: glyph extremes, every control, wrap back and top left
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h7F);
    send_char(CH_TAB);
    send_char(CH_BS);
    send_char(CH_CR);
    send_char(CH_NL);
    send_char(CH_BS);
    send_char(CH_CR);
    send_char(CH_BS);
    send_char(CH_TAB);
    send_char(CH_TAB);

    // zero cell width on the largest screen
    set_screen(12'd0, 12'd4095, 12'd4095);
    send_char(8'h78);
    send_char(CH_TAB);
    send_char(CH_NL);
    send_char(CH_BS);

    // screen narrower than a cell
    set_screen(12'd32, 12'd20, 12'd4095);
    send_char(8'h61);
    send_char(CH_NL);
    send_char(CH_BS);

    // one pixel screen: every check scrolls
    set_screen(12'd32, 12'd1, 12'd1);
    send_char(8'h62);
    send_char(CH_CR);
    send_char(CH_TAB);
    send_char(CH_BS);

    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 10) quiet = 1'b1;
      if (ph % 4 == 3) begin
        settle();
        set_reg(REG_SCREEN_HEIGHT, pick_dim());
      end else begin
        set_screen(pick_adv(), pick_dim(), pick_dim());
      end
      repeat (30) send_char(pick_char());
    end

    settle();
    if (fail_count == 0 && words_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
